>>> hdl/slum_pkg.sv
// Shared types and constants for the sorted list union merge unit.
package slum_pkg;

	localparam int IDX_PORT_W = 16;

	localparam logic [1:0] OP_APPEND_A = 2'd0;
	localparam logic [1:0] OP_APPEND_B = 2'd1;
	localparam logic [1:0] OP_MERGE    = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

endpackage

>>> hdl/sorted_list_union_merge_unit.sv
// Sorted list union merge unit: two list stores and a two-pointer merge sequencer.
// Loads (append to list A or B) leave busy low, so a request can be issued every cycle while
// busy is low. A merge request raises busy until every element of the union has been given
// (one result per cycle, set by the single read port of each list store) and then
// clears both lists and the overflow flag; a merge of two empty lists gives one result
// flagged union_empty without raising busy. Each result appears on the result ports for
// one cycle with strobe high, in the cycle after it is decided; the receiver cannot stall it
// and must take every strobe. A load into a full list is dropped and flagged on the next
// merge's results. No clearing pass follows reset.
module sorted_list_union_merge_unit #(
	parameter int LIST_DEPTH  = 32,
	parameter int INDEX_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       opcode,
	input  logic [slum_pkg::IDX_PORT_W-1:0]  index_value,
	output logic                             strobe,
	output logic [slum_pkg::IDX_PORT_W-1:0]  merged_index,
	output logic                             last_of_run,
	output logic                             union_empty,
	output logic                             overflow_seen
);

	import slum_pkg::*;

	localparam int SW = (INDEX_WIDTH < IDX_PORT_W) ? INDEX_WIDTH : IDX_PORT_W;
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

	state_t state_q, state_d;

	logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
	logic [CW-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
	logic          ovf_q, ovf_d;

	logic          accept;
	logic          we_a, we_b;
	logic [AW-1:0] rd_addr_a, rd_addr_b;
	logic [SW-1:0] head_a, head_b;

	logic          res_vld_d;
	logic [SW-1:0] res_val_d;
	logic          res_last_d, res_empty_d;

	logic          strobe_q;
	logic [SW-1:0] val_q;
	logic          last_q, empty_q, ovf_out_q;

	logic          av, bv, take_a, take_b;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q == ST_MERGE);

	assign we_a = accept && (opcode == OP_APPEND_A) && (cnt_a_q != FULL);
	assign we_b = accept && (opcode == OP_APPEND_B) && (cnt_b_q != FULL);

	slum_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(SW), .AW(AW)) u_list_a (
		.clk     (clk),
		.wr_en   (we_a),
		.wr_addr (cnt_a_q[AW-1:0]),
		.wr_data (index_value[SW-1:0]),
		.rd_addr (rd_addr_a),
		.rd_data (head_a)
	);

	slum_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(SW), .AW(AW)) u_list_b (
		.clk     (clk),
		.wr_en   (we_b),
		.wr_addr (cnt_b_q[AW-1:0]),
		.wr_data (index_value[SW-1:0]),
		.rd_addr (rd_addr_b),
		.rd_data (head_b)
	);

	always_comb begin
		state_d     = state_q;
		cnt_a_d     = cnt_a_q;
		cnt_b_d     = cnt_b_q;
		ptr_a_d     = ptr_a_q;
		ptr_b_d     = ptr_b_q;
		ovf_d       = ovf_q;
		res_vld_d   = 1'b0;
		res_val_d   = '0;
		res_last_d  = 1'b0;
		res_empty_d = 1'b0;
		av          = ptr_a_q < cnt_a_q;
		bv          = ptr_b_q < cnt_b_q;
		take_a      = 1'b0;
		take_b      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_APPEND_A: begin
							if (cnt_a_q == FULL) begin
								ovf_d = 1'b1;
							end else begin
								cnt_a_d = cnt_a_q + 1'b1;
							end
						end
						OP_APPEND_B: begin
							if (cnt_b_q == FULL) begin
								ovf_d = 1'b1;
							end else begin
								cnt_b_d = cnt_b_q + 1'b1;
							end
						end
						OP_MERGE: begin
							ptr_a_d = '0;
							ptr_b_d = '0;
							if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
								res_vld_d   = 1'b1;
								res_last_d  = 1'b1;
								res_empty_d = 1'b1;
								ovf_d       = 1'b0;
							end else begin
								state_d = ST_MERGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_MERGE: begin
				// heads come from the stores, addressed by last cycle's next pointers
				if (av && bv) begin
					take_a = (head_a <= head_b);
					take_b = (head_b <= head_a);
				end else begin
					take_a = av;
					take_b = !av;
				end
				res_val_d = take_a ? head_a : head_b;
				ptr_a_d   = ptr_a_q + CW'(take_a);
				ptr_b_d   = ptr_b_q + CW'(take_b);
				res_vld_d = 1'b1;
				if ((ptr_a_d >= cnt_a_q) && (ptr_b_d >= cnt_b_q)) begin
					res_last_d = 1'b1;
					cnt_a_d    = '0;
					cnt_b_d    = '0;
					ovf_d      = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rd_addr_a = (ptr_a_d < FULL) ? ptr_a_d[AW-1:0] : '0;
		rd_addr_b = (ptr_b_d < FULL) ? ptr_b_d[AW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			ptr_a_q  <= '0;
			ptr_b_q  <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_a_q  <= cnt_a_d;
			cnt_b_q  <= cnt_b_d;
			ptr_a_q  <= ptr_a_d;
			ptr_b_q  <= ptr_b_d;
			ovf_q    <= ovf_d;
			strobe_q <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld_d) begin
			val_q     <= res_val_d;
			last_q    <= res_last_d;
			empty_q   <= res_empty_d;
			ovf_out_q <= ovf_q;
		end
	end

	assign strobe        = strobe_q;
	assign merged_index  = IDX_PORT_W'(val_q);
	assign last_of_run   = last_q;
	assign union_empty   = empty_q;
	assign overflow_seen = ovf_out_q;

endmodule

>>> hdl/slum_list_ram.sv
// One list store: single write port, one registered read port.
module slum_list_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
